// ----- rtl/fvm_pkg.sv -----
`timescale 1ns / 1ps

package fvm_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_VDC     = 3'd0;
    localparam logic [2:0] CFG_PERIOD0 = 3'd1;

    localparam logic [14:0] VDC_RESET    = 15'd24576;
    localparam logic [16:0] PERIOD_RESET = 17'd65536;

    // Quarter-wave sine polynomial coefficients.
    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] SIN_B = 16'd21024;
    localparam logic [15:0] SIN_C = 16'd2320;
    localparam logic [15:0] SQRT3_HALF = 16'd28378;

    localparam int DIV_STEPS = 17;

    typedef struct packed {
        logic [1:0]          joint;
        logic                bad;
        logic signed [15:0]  uq;
        logic signed [17:0]  sn;
        logic signed [17:0]  cs;
    } t_trig;

    typedef struct packed {
        logic [1:0]  joint;
        logic        bad;
        logic [45:0] va;
        logic [45:0] vb;
        logic [45:0] vc;
    } t_phase;

endpackage

// ----- rtl/fvm_trig.sv -----
`timescale 1ns / 1ps

module fvm_trig import fvm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_angle,
    input  logic signed [15:0] i_uq,
    input  logic [1:0]         i_joint,
    input  logic               i_bad,
    output logic               o_valid,
    input  logic               i_ready,
    output t_trig              o_data
);

    localparam int NS = 5;

    logic [NS-1:0] r_vld;
    logic [NS:0]   adv;

    logic [1:0]         r_joint [NS];
    logic               r_bad   [NS];
    logic signed [15:0] r_uq    [NS];

    // Lane 0 is sine, lane 1 is cosine.
    logic [15:0] n1_z [2];
    logic        n1_neg [2];
    logic [15:0] r1_z [2];
    logic        r1_neg [2];
    logic [15:0] r2_z [2];
    logic [15:0] r2_z2 [2];
    logic        r2_neg [2];
    logic [15:0] r3_z [2];
    logic [15:0] r3_z2 [2];
    logic [15:0] r3_t [2];
    logic        r3_neg [2];
    logic [15:0] r4_z [2];
    logic [15:0] r4_t [2];
    logic        r4_neg [2];
    logic signed [17:0] r5_s [2];

    always_comb begin
        adv[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[NS-1];

    always_comb begin
        logic [15:0] ang;
        logic [15:0] rr;
        for (int l = 0; l < 2; l++) begin
            ang       = (l == 1) ? i_angle + 16'd16384 : i_angle;
            rr        = {1'b0, ang[13:0], 1'b0};
            n1_z[l]   = ang[14] ? 16'd32768 - rr : rr;
            n1_neg[l] = ang[15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_joint[0] <= i_joint;
            r_bad[0]   <= i_bad;
            r_uq[0]    <= i_uq;
        end
        for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
                r_joint[k] <= r_joint[k-1];
                r_bad[k]   <= r_bad[k-1];
                r_uq[k]    <= r_uq[k-1];
            end
        end
        for (int l = 0; l < 2; l++) begin
            if (adv[0]) begin
                r1_z[l]   <= n1_z[l];
                r1_neg[l] <= n1_neg[l];
            end
            if (adv[1]) begin
                r2_z[l]   <= r1_z[l];
                r2_z2[l]  <= 16'((32'(r1_z[l]) * 32'(r1_z[l])) >> 15);
                r2_neg[l] <= r1_neg[l];
            end
            if (adv[2]) begin
                r3_z[l]   <= r2_z[l];
                r3_z2[l]  <= r2_z2[l];
                r3_t[l]   <= SIN_B - 16'((32'(SIN_C) * 32'(r2_z2[l])) >> 15);
                r3_neg[l] <= r2_neg[l];
            end
            if (adv[3]) begin
                r4_z[l]   <= r3_z[l];
                r4_t[l]   <= SIN_A - 16'((32'(r3_t[l]) * 32'(r3_z2[l])) >> 15);
                r4_neg[l] <= r3_neg[l];
            end
            if (adv[4]) begin
                r5_s[l] <= r4_neg[l]
                    ? -$signed({2'b00, 16'((32'(r4_t[l]) * 32'(r4_z[l])) >> 15)})
                    :  $signed({2'b00, 16'((32'(r4_t[l]) * 32'(r4_z[l])) >> 15)});
            end
        end
    end

    always_comb begin
        o_data.joint = r_joint[NS-1];
        o_data.bad   = r_bad[NS-1];
        o_data.uq    = r_uq[NS-1];
        o_data.sn    = r5_s[0];
        o_data.cs    = r5_s[1];
    end

endmodule

// ----- rtl/fvm_clarke.sv -----
`timescale 1ns / 1ps

module fvm_clarke import fvm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_trig       i_data,
    input  logic [14:0] i_vdc,
    output logic        o_valid,
    input  logic        i_ready,
    output t_phase      o_data
);

    localparam int NS = 5;

    logic [NS-1:0] r_vld;
    logic [NS:0]   adv;

    logic [1:0] r_joint [NS];
    logic       r_bad   [NS];

    logic signed [33:0] r1_alpha;
    logic signed [33:0] r1_beta;
    logic signed [48:0] r2_ua;
    logic signed [47:0] r2_ha;
    logic signed [49:0] r2_pb;
    logic signed [50:0] r3_u [3];
    logic signed [50:0] r4_u [3];
    logic signed [50:0] r4_mx;
    logic signed [50:0] r4_mn;
    logic [45:0]        r5_v [3];
    logic signed [50:0] n4_mx;
    logic signed [50:0] n4_mn;
    logic [45:0]        n5_v [3];

    always_comb begin
        adv[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[NS-1];

    always_comb begin
        n4_mx = r3_u[0];
        n4_mn = r3_u[0];
        for (int l = 1; l < 3; l++) begin
            if (r3_u[l] > n4_mx) begin
                n4_mx = r3_u[l];
            end
            if (r3_u[l] < n4_mn) begin
                n4_mn = r3_u[l];
            end
        end
    end

    // Centre the midpoint of the phase swing on half the link voltage, then clamp.
    always_comb begin
        logic signed [53:0] e;
        logic [45:0]        full;
        full = {i_vdc, 31'b0};
        for (int l = 0; l < 3; l++) begin
            e = (54'(r4_u[l]) <<< 1) - 54'(r4_mx) - 54'(r4_mn)
                + $signed({9'b0, i_vdc, 30'b0});
            if (e < 0) begin
                n5_v[l] = '0;
            end else if (e > $signed({8'b0, full})) begin
                n5_v[l] = full;
            end else begin
                n5_v[l] = 46'(e);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_joint[0] <= i_data.joint;
            r_bad[0]   <= i_data.bad;
            r1_alpha   <= -(34'(i_data.sn) * 34'(i_data.uq));
            r1_beta    <= 34'(i_data.cs) * 34'(i_data.uq);
        end
        for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
                r_joint[k] <= r_joint[k-1];
                r_bad[k]   <= r_bad[k-1];
            end
        end
        if (adv[1]) begin
            r2_ua <= 49'(r1_alpha) <<< 15;
            r2_ha <= 48'(r1_alpha) <<< 14;
            r2_pb <= 50'(r1_beta) * $signed({34'b0, SQRT3_HALF});
        end
        if (adv[2]) begin
            r3_u[0] <= 51'(r2_ua);
            r3_u[1] <= -51'(r2_ha) + 51'(r2_pb);
            r3_u[2] <= -51'(r2_ha) - 51'(r2_pb);
        end
        if (adv[3]) begin
            r4_u  <= r3_u;
            r4_mx <= n4_mx;
            r4_mn <= n4_mn;
        end
        if (adv[4]) begin
            r5_v <= n5_v;
        end
    end

    always_comb begin
        o_data.joint = r_joint[NS-1];
        o_data.bad   = r_bad[NS-1];
        o_data.va    = r5_v[0];
        o_data.vb    = r5_v[1];
        o_data.vc    = r5_v[2];
    end

endmodule

// ----- rtl/fvm_div.sv -----
`timescale 1ns / 1ps

module fvm_div import fvm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_phase      i_data,
    input  logic [14:0] i_vdc,
    input  logic [16:0] i_period,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_joint,
    output logic [16:0] o_cmp [3]
);

    localparam int NS = DIV_STEPS;

    logic [NS-1:0] r_vld;
    logic [NS:0]   adv;

    logic [1:0]  r_joint  [NS];
    logic        r_zero   [NS];
    logic [16:0] r_period [NS];
    logic [45:0] r_v [NS][3];
    logic [45:0] r_r [NS][3];
    logic [16:0] r_q [NS][3];

    logic [45:0] s_v [NS][3];
    logic [45:0] s_r [NS][3];
    logic [16:0] s_q [NS][3];
    logic [16:0] s_period [NS];
    logic [45:0] n_r [NS][3];
    logic [16:0] n_q [NS][3];

    logic [47:0] d1;
    logic [47:0] d2;

    assign d1 = {2'b00, i_vdc, 31'b0};
    assign d2 = {1'b0, i_vdc, 32'b0};

    always_comb begin
        adv[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[NS-1];

    // Each stage retires one period bit: remainder = 2*remainder + bit*v,
    // then up to two subtractions of the divisor.
    always_comb begin
        logic [47:0] t;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                s_period[k] = i_period;
                s_v[k][0]   = i_data.va;
                s_v[k][1]   = i_data.vb;
                s_v[k][2]   = i_data.vc;
                for (int l = 0; l < 3; l++) begin
                    s_r[k][l] = '0;
                    s_q[k][l] = '0;
                end
            end else begin
                s_period[k] = r_period[k-1];
                for (int l = 0; l < 3; l++) begin
                    s_v[k][l] = r_v[k-1][l];
                    s_r[k][l] = r_r[k-1][l];
                    s_q[k][l] = r_q[k-1][l];
                end
            end
            for (int l = 0; l < 3; l++) begin
                t = {1'b0, s_r[k][l], 1'b0}
                    + (s_period[k][NS-1-k] ? {2'b00, s_v[k][l]} : 48'd0);
                if (t >= d2) begin
                    n_r[k][l] = 46'(t - d2);
                    n_q[k][l] = {s_q[k][l][15:0], 1'b0} + 17'd2;
                end else if (t >= d1) begin
                    n_r[k][l] = 46'(t - d1);
                    n_q[k][l] = {s_q[k][l][15:0], 1'b0} + 17'd1;
                end else begin
                    n_r[k][l] = 46'(t);
                    n_q[k][l] = {s_q[k][l][15:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
                if (k == 0) begin
                    r_joint[k] <= i_data.joint;
                    r_zero[k]  <= i_data.bad || (i_vdc == 15'd0);
                end else begin
                    r_joint[k] <= r_joint[k-1];
                    r_zero[k]  <= r_zero[k-1];
                end
                r_period[k] <= s_period[k];
                r_v[k]      <= s_v[k];
                r_r[k]      <= n_r[k];
                r_q[k]      <= n_q[k];
            end
        end
    end

    assign o_joint = r_joint[NS-1];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_cmp[l] = r_zero[NS-1] ? 17'd0 : r_q[NS-1][l];
        end
    end

endmodule

// ----- rtl/foc_voltage_modulator_top.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Signals                                    Transfer when
// input     in         i_in_valid, o_in_stall, angle/Uq/joint     valid high, stall low
// output    out        o_out_valid, i_out_stall, joint/compares   valid high, stall low
// config    in         i_cfg_valid, o_cfg_ready, index, data      valid and ready high
//
// One item enters per cycle while the output is not stalled; each result passes
// through 5 sine/cosine stages, 5 transform and centring stages, and one
// division stage per bit of the 17-bit compare value.
// Reset is synchronous and active low; it empties the pipeline and restores
// the link voltage and period registers to their defaults.
// A stalled output holds its result; empty stages behind it keep filling, so
// the input stalls only once every stage holds an item.

module foc_voltage_modulator_top import fvm_pkg::*; #(
    parameter int NUM_DRIVES = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_elec_angle,
    input  logic signed [15:0] i_q_voltage,
    input  logic [1:0]         i_joint_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_joint_out,
    output logic [16:0]        o_compare_a,
    output logic [16:0]        o_compare_b,
    output logic [16:0]        o_compare_c,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);

    // Configuration registers. Writes are to arrive only while the block is idle (the
    // user's duty; the block does not enforce it), so the pipeline reads them directly.
    logic [14:0] r_vdc;
    logic [16:0] r_period [NUM_DRIVES];

    logic   trig_rdy;
    logic   trig_vld;
    t_trig  trig_data;
    logic   clk_rdy;
    logic   clk_vld;
    t_phase clk_data;
    logic   div_rdy;
    logic [16:0] sel_period;
    logic [16:0] cmp [3];
    logic   in_bad;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vdc <= VDC_RESET;
            for (int j = 0; j < NUM_DRIVES; j++) begin
                r_period[j] <= PERIOD_RESET;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_VDC) begin
                r_vdc <= i_cfg_data[14:0];
            end
            for (int j = 0; j < NUM_DRIVES; j++) begin
                if (i_cfg_index == CFG_PERIOD0 + 3'(j)) begin
                    r_period[j] <= i_cfg_data;
                end
            end
        end
    end

    // A joint without a drive yields zero compare values.
    assign in_bad = ({1'b0, i_joint_index} >= 3'(NUM_DRIVES));

    assign o_in_stall = !trig_rdy;

    fvm_trig u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (trig_rdy),
        .i_angle (i_elec_angle),
        .i_uq    (i_q_voltage),
        .i_joint (i_joint_index),
        .i_bad   (in_bad),
        .o_valid (trig_vld),
        .i_ready (clk_rdy),
        .o_data  (trig_data)
    );

    fvm_clarke u_clarke (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (trig_vld),
        .o_ready (clk_rdy),
        .i_data  (trig_data),
        .i_vdc   (r_vdc),
        .o_valid (clk_vld),
        .i_ready (div_rdy),
        .o_data  (clk_data)
    );

    // Period of the joint whose item enters the divider.
    always_comb begin
        sel_period = '0;
        for (int j = 0; j < NUM_DRIVES; j++) begin
            if (clk_data.joint == 2'(j)) begin
                sel_period = r_period[j];
            end
        end
    end

    fvm_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (clk_vld),
        .o_ready  (div_rdy),
        .i_data   (clk_data),
        .i_vdc    (r_vdc),
        .i_period (sel_period),
        .o_valid  (o_out_valid),
        .i_ready  (!i_out_stall),
        .o_joint  (o_joint_out),
        .o_cmp    (cmp)
    );

    assign o_compare_a = cmp[0];
    assign o_compare_b = cmp[1];
    assign o_compare_c = cmp[2];

endmodule
